// ===== sv/twbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twbc_pkg
// Shared types and codes of the two-way write-back block cache: function and
// result codes, the result record and the size of the result queue.
// ----------------------------------------------------------------------------
package twbc_pkg;

  localparam int TAG_W  = 12;
  localparam int DATA_W = 8;
  localparam int KIND_W = 3;
  localparam int FUNC_W = 2;

  // Input function codes
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FILL  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_DRAIN = 2'd3;

  // Result kind codes
  localparam logic [KIND_W-1:0] KIND_READ_DATA  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE_DONE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WB_REQ     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FILL_REQ   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DRAINED    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REJECT     = 3'd5;

  // Result queue geometry
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  line_tag;
    logic              way;
    logic [DATA_W-1:0] read_data;
    logic              last;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/two_way_writeback_block_cache_core.sv =====
// Results: each result passes the response stage and then the result queue before it is
//   offered; the pending access of the last fill byte first waits in comp_pending.
// Throughput: one item per cycle while the result queue has room for two more results;
//   the last fill byte holds off input while the line memory performs the pending access,
//   and the last drained byte may hold it off while its two results enter the result queue.
// Reset: the low RAM is swept to zero with in_ready low; lines invalid.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_way_writeback_block_cache_core
// Byte access engine with a direct low RAM and a two-line fully associative
// write-back cache, with line drain and fill sequencing.
// ----------------------------------------------------------------------------
module two_way_writeback_block_cache_core
  import twbc_pkg::*;
#(
  parameter int LINE_BYTES = 4096,
  parameter int ADDR_BITS  = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FUNC_W-1:0]    func,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [DATA_W-1:0]    write_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    kind,
  output logic [TAG_W-1:0]     line_tag,
  output logic                 way,
  output logic [DATA_W-1:0]    read_data,
  output logic                 last
);

  localparam int OFF_W = $clog2(LINE_BYTES);
  localparam int AX_W  = (ADDR_BITS > OFF_W) ? ADDR_BITS : OFF_W + 1;
  localparam int TF_W  = AX_W - OFF_W;
  localparam logic [OFF_W-1:0] LAST_IDX = OFF_W'(LINE_BYTES - 1);

  typedef enum logic [1:0] {PH_IDLE, PH_DRAIN, PH_FILL} phase_t;
  typedef enum logic [1:0] {SRC_NONE, SRC_LOW, SRC_LINE} src_t;

  // State registers
  phase_t            phase, phase_next;
  logic [TF_W-1:0]   tag0, tag0_next;
  logic [TF_W-1:0]   tag1, tag1_next;
  logic [1:0]        valid_bits, valid_bits_next;
  logic [1:0]        dirty_bits, dirty_bits_next;
  logic              victim, victim_next;
  logic [OFF_W-1:0]  byte_cnt, byte_cnt_next;
  logic              pend_write, pend_write_next;
  logic [OFF_W-1:0]  pend_off, pend_off_next;
  logic [TF_W-1:0]   pend_tag, pend_tag_next;
  logic [DATA_W-1:0] pend_data, pend_data_next;
  logic              comp_pending, comp_pending_next;
  logic              comp_way, comp_way_next;
  logic              clearing, clearing_next;
  logic [OFF_W-1:0]  clear_addr, clear_addr_next;

  // Response stage
  logic              s1_valid, s1_valid_next;
  logic              s1_second, s1_second_next;
  logic [KIND_W-1:0] s1_kind, s1_kind_next;
  logic [TAG_W-1:0]  s1_tag, s1_tag_next;
  logic [TAG_W-1:0]  s1_tag2, s1_tag2_next;
  logic              s1_way, s1_way_next;
  src_t              s1_src, s1_src_next;

  // Memory ports
  logic              low_we;
  logic [OFF_W-1:0]  low_addr;
  logic [DATA_W-1:0] low_wdata;
  logic [DATA_W-1:0] low_rdata;
  logic              line_we;
  logic [OFF_W:0]    line_addr;
  logic [DATA_W-1:0] line_wdata;
  logic [DATA_W-1:0] line_rdata;

  // Decode and handshake
  logic [AX_W-1:0]      addr_x;
  logic [OFF_W-1:0]     a_off;
  logic [TF_W-1:0]      a_tag;
  logic [TF_W-1:0]      v_tag;
  logic                 hit0, hit1, hit, hit_way;
  logic                 cnt_last;
  logic [1:0]           s1_cnt;
  logic [OUT_CNT_W-1:0] out_cnt;
  logic                 room;
  logic                 in_fire;
  logic                 push0, push1;
  result_t              res0, res1, res_out;

  assign addr_x   = AX_W'(address);
  assign a_off    = addr_x[OFF_W-1:0];
  assign a_tag    = addr_x[AX_W-1:OFF_W];
  assign v_tag    = victim ? tag1 : tag0;
  assign hit0     = valid_bits[0] && (tag0 == a_tag);
  assign hit1     = valid_bits[1] && (tag1 == a_tag);
  assign hit      = hit0 || hit1;
  assign hit_way  = !hit0;
  assign cnt_last = (byte_cnt == LAST_IDX);

  // Reserve queue space for the worst case of two results per item
  assign s1_cnt   = {1'b0, s1_valid} + {1'b0, s1_second};
  assign room     = ({1'b0, out_cnt} + 4'(s1_cnt) + 4'd2) <= 4'(OUT_DEPTH);
  assign in_ready = !clearing && !comp_pending && room;
  assign in_fire  = in_valid && in_ready;

  // Next-state and memory control
  always_comb begin
    phase_next        = phase;
    tag0_next         = tag0;
    tag1_next         = tag1;
    valid_bits_next   = valid_bits;
    dirty_bits_next   = dirty_bits;
    victim_next       = victim;
    byte_cnt_next     = byte_cnt;
    pend_write_next   = pend_write;
    pend_off_next     = pend_off;
    pend_tag_next     = pend_tag;
    pend_data_next    = pend_data;
    comp_pending_next = comp_pending;
    comp_way_next     = comp_way;
    clearing_next     = clearing;
    clear_addr_next   = clear_addr;

    s1_valid_next  = 1'b0;
    s1_second_next = 1'b0;
    s1_kind_next   = KIND_REJECT;
    s1_tag_next    = '0;
    s1_tag2_next   = '0;
    s1_way_next    = 1'b0;
    s1_src_next    = SRC_NONE;

    low_we     = 1'b0;
    low_addr   = a_off;
    low_wdata  = write_data;
    line_we    = 1'b0;
    line_addr  = {victim, byte_cnt};
    line_wdata = write_data;

    if (clearing) begin
      // Sweep the low RAM to zero
      low_we          = 1'b1;
      low_addr        = clear_addr;
      low_wdata       = '0;
      clear_addr_next = clear_addr + OFF_W'(1);
      if (clear_addr == LAST_IDX) begin
        clearing_next = 1'b0;
      end
    end else if (comp_pending) begin
      // Complete the access that waited for the fill
      comp_pending_next = 1'b0;
      line_addr         = {comp_way, pend_off};
      s1_valid_next     = 1'b1;
      s1_way_next       = comp_way;
      if (pend_write) begin
        line_we                   = 1'b1;
        line_wdata                = pend_data;
        dirty_bits_next[comp_way] = 1'b1;
        s1_kind_next              = KIND_WRITE_DONE;
      end else begin
        s1_kind_next = KIND_READ_DATA;
        s1_src_next  = SRC_LINE;
      end
    end else if (in_fire) begin
      case (phase)
        PH_IDLE: begin
          s1_valid_next = 1'b1;
          if (func == FUNC_FILL || func == FUNC_DRAIN) begin
            s1_kind_next = KIND_REJECT;
          end else if (a_tag == '0) begin
            // Direct low RAM
            if (func == FUNC_WRITE) begin
              low_we       = 1'b1;
              s1_kind_next = KIND_WRITE_DONE;
            end else begin
              s1_kind_next = KIND_READ_DATA;
              s1_src_next  = SRC_LOW;
            end
          end else if (hit) begin
            line_addr   = {hit_way, a_off};
            s1_way_next = hit_way;
            if (func == FUNC_WRITE) begin
              line_we                  = 1'b1;
              dirty_bits_next[hit_way] = 1'b1;
              s1_kind_next             = KIND_WRITE_DONE;
            end else begin
              s1_kind_next = KIND_READ_DATA;
              s1_src_next  = SRC_LINE;
            end
          end else begin
            // Miss: park the access, drain the victim if dirty, else fill
            pend_write_next = (func == FUNC_WRITE);
            pend_off_next   = a_off;
            pend_tag_next   = a_tag;
            pend_data_next  = write_data;
            byte_cnt_next   = '0;
            s1_way_next     = victim;
            if (valid_bits[victim] && dirty_bits[victim]) begin
              phase_next   = PH_DRAIN;
              s1_kind_next = KIND_WB_REQ;
              s1_tag_next  = TAG_W'(v_tag);
            end else begin
              phase_next   = PH_FILL;
              s1_kind_next = KIND_FILL_REQ;
              s1_tag_next  = TAG_W'(a_tag);
            end
          end
        end
        PH_DRAIN: begin
          s1_valid_next = 1'b1;
          if (func == FUNC_DRAIN) begin
            s1_kind_next = KIND_DRAINED;
            s1_src_next  = SRC_LINE;
            s1_way_next  = victim;
            if (cnt_last) begin
              s1_second_next          = 1'b1;
              s1_tag2_next            = TAG_W'(pend_tag);
              dirty_bits_next[victim] = 1'b0;
              byte_cnt_next           = '0;
              phase_next              = PH_FILL;
            end else begin
              byte_cnt_next = byte_cnt + OFF_W'(1);
            end
          end
        end
        PH_FILL: begin
          if (func != FUNC_FILL) begin
            s1_valid_next = 1'b1;
          end else begin
            line_we = 1'b1;
            if (cnt_last) begin
              // Install the line and schedule the pending access
              byte_cnt_next           = '0;
              valid_bits_next[victim] = 1'b1;
              dirty_bits_next[victim] = 1'b0;
              victim_next             = !victim;
              phase_next              = PH_IDLE;
              comp_pending_next       = 1'b1;
              comp_way_next           = victim;
              if (victim) begin
                tag1_next = pend_tag;
              end else begin
                tag0_next = pend_tag;
              end
            end else begin
              byte_cnt_next = byte_cnt + OFF_W'(1);
            end
          end
        end
        default: begin
          s1_valid_next = 1'b1;
          phase_next    = PH_IDLE;
        end
      endcase
    end
  end

  // Hold state and control of the response stage
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tag0         <= '0;
      tag1         <= '0;
      valid_bits   <= '0;
      dirty_bits   <= '0;
      victim       <= 1'b0;
      byte_cnt     <= '0;
      pend_write   <= 1'b0;
      pend_off     <= '0;
      pend_tag     <= '0;
      pend_data    <= '0;
      comp_pending <= 1'b0;
      comp_way     <= 1'b0;
      clearing     <= 1'b1;
      clear_addr   <= '0;
      s1_valid     <= 1'b0;
      s1_second    <= 1'b0;
    end else begin
      phase        <= phase_next;
      tag0         <= tag0_next;
      tag1         <= tag1_next;
      valid_bits   <= valid_bits_next;
      dirty_bits   <= dirty_bits_next;
      victim       <= victim_next;
      byte_cnt     <= byte_cnt_next;
      pend_write   <= pend_write_next;
      pend_off     <= pend_off_next;
      pend_tag     <= pend_tag_next;
      pend_data    <= pend_data_next;
      comp_pending <= comp_pending_next;
      comp_way     <= comp_way_next;
      clearing     <= clearing_next;
      clear_addr   <= clear_addr_next;
      s1_valid     <= s1_valid_next;
      s1_second    <= s1_second_next;
    end
  end

  // Response stage payload
  always_ff @(posedge clk) begin
    s1_kind <= s1_kind_next;
    s1_tag  <= s1_tag_next;
    s1_tag2 <= s1_tag2_next;
    s1_way  <= s1_way_next;
    s1_src  <= s1_src_next;
  end

  twbc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LINE_BYTES)
  ) u_low_ram (
    .clk   (clk),
    .we    (low_we),
    .addr  (low_addr),
    .wdata (low_wdata),
    .rdata (low_rdata)
  );

  twbc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (2 * LINE_BYTES)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .addr  (line_addr),
    .wdata (line_wdata),
    .rdata (line_rdata)
  );

  // Form results with the memory read data
  always_comb begin
    res0.kind     = s1_kind;
    res0.line_tag = s1_tag;
    res0.way      = s1_way;
    res0.last     = !s1_second;
    case (s1_src)
      SRC_LOW:  res0.read_data = low_rdata;
      SRC_LINE: res0.read_data = line_rdata;
      default:  res0.read_data = '0;
    endcase
    res1.kind      = KIND_FILL_REQ;
    res1.line_tag  = s1_tag2;
    res1.way       = s1_way;
    res1.read_data = '0;
    res1.last      = 1'b1;
  end

  assign push0 = s1_valid;
  assign push1 = s1_valid && s1_second;

  twbc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .push1     (push1),
    .din0      (res0),
    .din1      (res1),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (res_out),
    .count     (out_cnt)
  );

  assign kind      = res_out.kind;
  assign line_tag  = res_out.line_tag;
  assign way       = res_out.way;
  assign read_data = res_out.read_data;
  assign last      = res_out.last;

  // Checks
  a_comp_idle: assert property (@(posedge clk) disable iff (rst)
    comp_pending |-> (phase == PH_IDLE))
    else $error("pending completion outside idle phase");

  a_comp_origin: assert property (@(posedge clk) disable iff (rst)
    comp_pending |-> $past(in_fire && phase == PH_FILL && cnt_last))
    else $error("pending completion without a last fill byte");

  a_drain_dirty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DRAIN) |-> (valid_bits[victim] && dirty_bits[victim]))
    else $error("draining a line that is not valid and dirty");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, out_cnt} + 4'(s1_cnt)) <= 4'(OUT_DEPTH))
    else $error("result queue overcommitted");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s1_valid && out_cnt == '0 && !comp_pending))
    else $error("activity during low RAM clearing");

endmodule
`default_nettype wire

// ===== sv/twbc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twbc_ram
// Generic single-port synchronous RAM with one write and one registered read
// per cycle.
// ----------------------------------------------------------------------------
module twbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== sv/twbc_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twbc_out_fifo
// Small result queue: takes up to two results per cycle, hands out one per
// transfer on the output channel.
// ----------------------------------------------------------------------------
module twbc_out_fifo
  import twbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push0,
  input  logic                 push1,
  input  result_t              din0,
  input  result_t              din1,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              dout,
  output logic [OUT_CNT_W-1:0] count
);

  result_t              mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] wr_ptr_inc;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [1:0]           n_push;
  logic                 pop;

  assign out_valid  = (count != '0);
  assign dout       = mem[rd_ptr];
  assign pop        = out_valid && out_ready;
  assign n_push     = {1'b0, push0} + {1'b0, push1};
  assign wr_ptr_inc = wr_ptr + OUT_PTR_W'(1);

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUT_PTR_W'(n_push);
      rd_ptr <= rd_ptr + OUT_PTR_W'(pop);
      count  <= count + OUT_CNT_W'(n_push) - OUT_CNT_W'(pop);
    end
  end

  // Store incoming results
  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= din0;
    end
    if (push1) begin
      mem[wr_ptr_inc] <= din1;
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_two_way_writeback_block_cache_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_way_writeback_block_cache_core
// Self-checking bench for the two-way write-back block cache. A cycle-free
// predictor tracks low RAM, both lines, tags, valid and dirty marks, the
// victim pointer and the drain/fill sequencing. It queues the results due for
// each accepted item, and a monitor compares every output transfer against
// the oldest queued entry. Directed tests cover low RAM extremes, rejects,
// clean and dirty misses. Back-pressure and random mixed traffic follow.
// ----------------------------------------------------------------------------
module tb_two_way_writeback_block_cache_core;
  import twbc_pkg::*;

  localparam int LINE_BYTES = 4096;
  localparam int ADDR_BITS  = 24;
  localparam int OFF_W      = $clog2(LINE_BYTES);
  localparam int LAST_IDX   = LINE_BYTES - 1;

  typedef enum logic [1:0] {LINE_IDLE, LINE_DRAIN, LINE_FILL} xfer_phase_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [FUNC_W-1:0]    func;
  logic [ADDR_BITS-1:0] address;
  logic [DATA_W-1:0]    write_data;
  logic                 out_valid;
  logic                 out_ready;
  logic [KIND_W-1:0]    kind;
  logic [TAG_W-1:0]     line_tag;
  logic                 way;
  logic [DATA_W-1:0]    read_data;
  logic                 last;

  // Predicted cache state
  logic [DATA_W-1:0]    low_mem [LINE_BYTES];
  logic [DATA_W-1:0]    line_mem [2][LINE_BYTES];
  logic [TAG_W-1:0]     resident_tag [2];
  logic [1:0]           resident_valid;
  logic [1:0]           resident_dirty;
  logic                 victim;
  xfer_phase_t          xfer_phase;
  int unsigned          xfer_idx;
  logic                 held_write;
  logic [ADDR_BITS-1:0] held_addr;
  logic [DATA_W-1:0]    held_data;

  result_t awaited_results[$];
  int      mismatches;
  bit      gaps_enabled;
  bit      stalls_enabled;
  int      rx_hold_cycles;

  two_way_writeback_block_cache_core #(
    .LINE_BYTES(LINE_BYTES),
    .ADDR_BITS (ADDR_BITS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .address   (address),
    .write_data(write_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .line_tag  (line_tag),
    .way       (way),
    .read_data (read_data),
    .last      (last)
  );

  // Generate the 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  initial begin
    #150_000_000;
    $display("two_way_writeback_block_cache_core: mismatch");
    $finish;
  end

  function automatic void flag_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
  endfunction

  function automatic void queue_result(logic [KIND_W-1:0] k, logic [TAG_W-1:0] t, logic w,
                                       logic [DATA_W-1:0] d, logic l);
    result_t r;
    r.kind      = k;
    r.line_tag  = t;
    r.way       = w;
    r.read_data = d;
    r.last      = l;
    awaited_results.push_back(r);
  endfunction

  // Read or write one byte of a resident line
  function automatic void touch_line(logic w, logic wr, logic [OFF_W-1:0] off,
                                     logic [DATA_W-1:0] d);
    if (wr) begin
      line_mem[w][off]  = d;
      resident_dirty[w] = 1'b1;
      queue_result(KIND_WRITE_DONE, '0, w, '0, 1'b1);
    end else begin
      queue_result(KIND_READ_DATA, '0, w, line_mem[w][off], 1'b1);
    end
  endfunction

  // Advance the predicted cache by one accepted transfer
  function automatic void predict_cache_item(logic [FUNC_W-1:0] f, logic [ADDR_BITS-1:0] a,
                                             logic [DATA_W-1:0] d);
    logic [TAG_W-1:0] tg;
    logic [OFF_W-1:0] off;
    logic             v;
    bit               hit;
    logic             hit_way;
    tg      = a[ADDR_BITS-1:OFF_W];
    off     = a[OFF_W-1:0];
    v       = victim;
    hit     = 1'b0;
    hit_way = 1'b0;
    case (xfer_phase)
      LINE_IDLE: begin
        if (f == FUNC_FILL || f == FUNC_DRAIN) begin
          queue_result(KIND_REJECT, '0, 1'b0, '0, 1'b1);
        end else if (a < LINE_BYTES) begin
          if (f == FUNC_WRITE) begin
            low_mem[off] = d;
            queue_result(KIND_WRITE_DONE, '0, 1'b0, '0, 1'b1);
          end else begin
            queue_result(KIND_READ_DATA, '0, 1'b0, low_mem[off], 1'b1);
          end
        end else begin
          // way 0 wins a tie
          for (int w = 1; w >= 0; w--) begin
            if (resident_valid[w] && resident_tag[w] == tg) begin
              hit     = 1'b1;
              hit_way = w[0];
            end
          end
          if (hit) begin
            touch_line(hit_way, f == FUNC_WRITE, off, d);
          end else begin
            held_write = (f == FUNC_WRITE);
            held_addr  = a;
            held_data  = d;
            xfer_idx   = 0;
            if (resident_valid[v] && resident_dirty[v]) begin
              xfer_phase = LINE_DRAIN;
              queue_result(KIND_WB_REQ, resident_tag[v], v, '0, 1'b1);
            end else begin
              xfer_phase = LINE_FILL;
              queue_result(KIND_FILL_REQ, tg, v, '0, 1'b1);
            end
          end
        end
      end
      LINE_DRAIN: begin
        if (f != FUNC_DRAIN) begin
          queue_result(KIND_REJECT, '0, 1'b0, '0, 1'b1);
        end else if (xfer_idx < LAST_IDX) begin
          queue_result(KIND_DRAINED, '0, v, line_mem[v][xfer_idx], 1'b1);
          xfer_idx++;
        end else begin
          // last drained byte also issues the fill request
          queue_result(KIND_DRAINED, '0, v, line_mem[v][xfer_idx], 1'b0);
          resident_dirty[v] = 1'b0;
          xfer_idx          = 0;
          xfer_phase        = LINE_FILL;
          queue_result(KIND_FILL_REQ, held_addr[ADDR_BITS-1:OFF_W], v, '0, 1'b1);
        end
      end
      default: begin
        if (f != FUNC_FILL) begin
          queue_result(KIND_REJECT, '0, 1'b0, '0, 1'b1);
        end else begin
          line_mem[v][xfer_idx] = d;
          if (xfer_idx < LAST_IDX) begin
            xfer_idx++;
          end else begin
            // install the line, then finish the held access
            xfer_idx          = 0;
            resident_tag[v]   = held_addr[ADDR_BITS-1:OFF_W];
            resident_valid[v] = 1'b1;
            resident_dirty[v] = 1'b0;
            victim            = ~v;
            xfer_phase        = LINE_IDLE;
            touch_line(v, held_write, held_addr[OFF_W-1:0], held_data);
          end
        end
      end
    endcase
  endfunction

  // Offer one item, hold it until transfer, then predict its results
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [ADDR_BITS-1:0] a,
                           input logic [DATA_W-1:0] d);
    int gap;
    if (gaps_enabled && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    address    <= a;
    write_data <= d;
    do @(posedge clk); while (!in_ready);
    predict_cache_item(f, a, d);
    @(negedge clk);
  endtask

  // Drop valid and wait until every queued result has arrived
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Feed drain or fill bytes until the miss completes, with occasional stray items
  task automatic run_line_transfer(input int noise_permille);
    logic [FUNC_W-1:0] f;
    while (xfer_phase != LINE_IDLE) begin
      if ($urandom_range(0, 999) < noise_permille)
        f = FUNC_W'($urandom_range(0, 3));
      else
        f = (xfer_phase == LINE_DRAIN) ? FUNC_DRAIN : FUNC_FILL;
      send_item(f, ADDR_BITS'($urandom), DATA_W'($urandom));
    end
  endtask

  task automatic test_low_ram();
    send_item(FUNC_WRITE, 24'h000000, 8'hA5);
    send_item(FUNC_WRITE, 24'h000FFF, 8'hFF);
    send_item(FUNC_READ,  24'h000000, 8'h00);
    send_item(FUNC_READ,  24'h000FFF, 8'h00);
    send_item(FUNC_READ,  24'h000001, 8'hFF);
    send_item(FUNC_WRITE, 24'h000FFF, 8'h00);
    send_item(FUNC_READ,  24'h000FFF, 8'h5A);
  endtask

  task automatic test_idle_rejects();
    send_item(FUNC_FILL,  24'hFFFFFF, 8'hFF);
    send_item(FUNC_DRAIN, 24'h000000, 8'h00);
  endtask

  // Miss into an empty way: fill request, stray items rejected, then fill
  task automatic test_clean_miss();
    send_item(FUNC_READ,  24'hFFFFFF, 8'h00);
    send_item(FUNC_READ,  24'hFFFFFF, 8'h11);
    send_item(FUNC_WRITE, 24'h000010, 8'h22);
    send_item(FUNC_DRAIN, 24'h000000, 8'h33);
    run_line_transfer(0);
  endtask

  // Write miss into the other way, then hit both ways
  task automatic test_write_miss();
    send_item(FUNC_WRITE, 24'h001000, 8'h3C);
    run_line_transfer(0);
    send_item(FUNC_READ, 24'h001000, 8'h00);
    send_item(FUNC_READ, 24'hFFF000, 8'h00);
  endtask

  // Dirty the victim, then miss: writeback, drain, fill, pending read
  task automatic test_dirty_eviction();
    send_item(FUNC_WRITE, 24'hFFF123, 8'hC3);
    send_item(FUNC_READ,  24'h800800, 8'h00);
    send_item(FUNC_FILL,  24'h123456, 8'h44);
    send_item(FUNC_WRITE, 24'h800800, 8'h55);
    run_line_transfer(0);
  endtask

  // Hold the receiver off while the sender keeps offering, then pause
  task automatic test_output_stall();
    bit saved_gaps;
    saved_gaps     = gaps_enabled;
    gaps_enabled   = 1'b0;
    rx_hold_cycles = 300;
    for (int i = 0; i < 24; i++)
      send_item(FUNC_W'($urandom_range(0, 1)), ADDR_BITS'($urandom_range(0, LAST_IDX)),
                DATA_W'($urandom));
    wait_all_results();
    gaps_enabled = saved_gaps;
  endtask

  task automatic test_random_traffic(input int count);
    int                   pick;
    int                   misses_left;
    logic [ADDR_BITS-1:0] a;
    logic [TAG_W-1:0]     tg;
    logic                 w;
    misses_left = 6;
    for (int i = 0; i < count; i++) begin
      // run the tail without any idling
      if (i == count - 200) begin
        gaps_enabled   = 1'b0;
        stalls_enabled = 1'b0;
      end
      pick = $urandom_range(0, 999);
      if (pick < 300) begin
        if ($urandom_range(0, 9) == 0)
          a = $urandom_range(0, 1) ? ADDR_BITS'(LAST_IDX) : '0;
        else
          a = ADDR_BITS'($urandom_range(0, LAST_IDX));
        send_item(FUNC_W'($urandom_range(0, 1)), a, DATA_W'($urandom));
      end else if (pick < 700 && resident_valid != 2'b00) begin
        w = 1'($urandom_range(0, 1));
        if (!resident_valid[w])
          w = ~w;
        a = {resident_tag[w], OFF_W'($urandom_range(0, LAST_IDX))};
        send_item(FUNC_W'($urandom_range(0, 1)), a, DATA_W'($urandom));
      end else if (pick < 880) begin
        send_item(FUNC_W'($urandom_range(2, 3)), ADDR_BITS'($urandom), DATA_W'($urandom));
      end else if (pick < 886 && misses_left > 0) begin
        do
          tg = TAG_W'($urandom_range(1, (1 << TAG_W) - 1));
        while ((resident_valid[0] && resident_tag[0] == tg) ||
               (resident_valid[1] && resident_tag[1] == tg));
        misses_left--;
        send_item(FUNC_W'($urandom_range(0, 1)), {tg, OFF_W'($urandom_range(0, LAST_IDX))},
                  DATA_W'($urandom));
        run_line_transfer(3);
      end else begin
        if (pick > 990)
          wait_all_results();
        send_item(FUNC_READ, ADDR_BITS'($urandom_range(0, LAST_IDX)), DATA_W'($urandom));
      end
    end
  endtask

  // Drive the receiver: random stall bursts and requested long holds
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        n              = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else if (stalls_enabled && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each output transfer with the oldest queued result
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("unexpected result, kind", 0, kind);
      end else begin
        want = awaited_results.pop_front();
        if (want.kind !== kind)
          flag_mismatch("kind", want.kind, kind);
        if (want.line_tag !== line_tag)
          flag_mismatch("line_tag", want.line_tag, line_tag);
        if (want.way !== way)
          flag_mismatch("way", want.way, way);
        if (want.read_data !== read_data)
          flag_mismatch("read_data", want.read_data, read_data);
        if (want.last !== last)
          flag_mismatch("last", want.last, last);
      end
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    func           = FUNC_READ;
    address        = '0;
    write_data     = '0;
    mismatches     = 0;
    gaps_enabled   = 1'b1;
    stalls_enabled = 1'b1;
    rx_hold_cycles = 0;
    for (int i = 0; i < LINE_BYTES; i++) begin
      low_mem[i]     = '0;
      line_mem[0][i] = '0;
      line_mem[1][i] = '0;
    end
    resident_tag[0] = '0;
    resident_tag[1] = '0;
    resident_valid  = 2'b00;
    resident_dirty  = 2'b00;
    victim          = 1'b0;
    xfer_phase      = LINE_IDLE;
    xfer_idx        = 0;
    held_write      = 1'b0;
    held_addr       = '0;
    held_data       = '0;

    // Hold reset, then release it at a falling edge; the low RAM sweep is covered by in_ready
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_low_ram();
    test_idle_rejects();
    test_clean_miss();
    test_write_miss();
    test_dirty_eviction();
    test_output_stall();
    test_random_traffic(1600);

    wait_all_results();
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("two_way_writeback_block_cache_core: match");
    else
      $display("two_way_writeback_block_cache_core: mismatch");
    $finish;
  end

endmodule
